FILE: rtl/csvp_pkg.sv
`default_nettype none

package csvp_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    typedef enum logic [1:0] {
        KIND_DATA         = 2'd0,
        KIND_FIELD        = 2'd1,
        KIND_FIELD_RECORD = 2'd2,
        KIND_RECORD       = 2'd3
    } t_kind;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SEPARATOR = 1'b0,
        REG_QUOTE     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] separator_char;
        logic [7:0] quote_char;
    } t_cfg;

    typedef struct packed {
        logic in_quoted;
        logic after_closing_quote;
        logic field_has_data;
        logic after_record_cr;
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/csvp_in_if.sv
`default_nettype none

interface csvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

FILE: rtl/csvp_out_if.sv
`default_nettype none

interface csvp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;

    modport source (output valid, output out_kind, output out_byte, input ready);
    modport sink   (input valid, input out_kind, input out_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/csvp_apb_regs.sv
`default_nettype none

module csvp_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csvp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [csvp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [csvp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output csvp_pkg::t_cfg                      o_cfg
);
    import csvp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_SEPARATOR: n_cfg.separator_char = pwdata[7:0];
                REG_QUOTE:     n_cfg.quote_char     = pwdata[7:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_char <= SEP_RESET;
            r_cfg.quote_char     <= QUOTE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_SEPARATOR: prdata[7:0] = r_cfg.separator_char;
            REG_QUOTE:     prdata[7:0] = r_cfg.quote_char;
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/csvp_step.sv
`default_nettype none

module csvp_step (
    input  wire csvp_pkg::t_cfg   i_cfg,
    input  wire csvp_pkg::t_state i_state,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eos,
    output csvp_pkg::t_state      o_state,
    output logic                  o_emit,
    output csvp_pkg::t_kind       o_kind,
    output logic [7:0]            o_byte
);
    import csvp_pkg::*;

    t_state w_st;
    logic   w_skip;

    always_comb begin
        w_st   = i_state;
        w_skip = 1'b0;
        o_emit = 1'b0;
        o_kind = KIND_DATA;
        o_byte = 8'd0;
        if (i_eos) begin
            o_kind = i_state.field_has_data ? KIND_FIELD_RECORD : KIND_RECORD;
            o_emit = 1'b1;
            w_st   = '0;
        end else begin
            // LF right after a record-ending CR is swallowed
            if (w_st.after_record_cr) begin
                w_st.after_record_cr = 1'b0;
                if (i_byte == CHAR_LF) begin
                    w_skip = 1'b1;
                end
            end
            if (!w_skip) begin
                if (i_byte == i_cfg.quote_char) begin
                    if (w_st.in_quoted) begin
                        w_st.in_quoted           = 1'b0;
                        w_st.after_closing_quote = 1'b1;
                    end else if (w_st.after_closing_quote) begin
                        // doubled quote: literal quote, back inside quotes
                        w_st.after_closing_quote = 1'b0;
                        w_st.in_quoted           = 1'b1;
                        w_st.field_has_data      = 1'b1;
                        o_emit                   = 1'b1;
                        o_byte                   = i_cfg.quote_char;
                    end else begin
                        w_st.in_quoted = 1'b1;
                    end
                end else begin
                    w_st.after_closing_quote = 1'b0;
                    if (i_byte == i_cfg.separator_char) begin
                        o_emit = 1'b1;
                        if (w_st.in_quoted) begin
                            w_st.field_has_data = 1'b1;
                            o_byte              = i_byte;
                        end else begin
                            w_st.field_has_data = 1'b0;
                            o_kind              = KIND_FIELD;
                        end
                    end else if (!w_st.in_quoted &&
                                 (i_byte == CHAR_CR || i_byte == CHAR_LF)) begin
                        w_st                 = '0;
                        w_st.after_record_cr = (i_byte == CHAR_CR);
                        o_emit               = 1'b1;
                        o_kind               = KIND_FIELD_RECORD;
                    end else begin
                        w_st.field_has_data = 1'b1;
                        o_emit              = 1'b1;
                        o_byte              = i_byte;
                    end
                end
            end
        end
        o_state = w_st;
    end

endmodule

`default_nettype wire

FILE: rtl/csv_record_parser_top.sv
// An accepted byte is held in the input register, then its result in the result register.
// One byte per cycle unless output stalls; the parse state update is one flag step per byte.
// Bytes that give no result (quotes, swallowed LF) retire without waiting on the output side.
// Reset (synchronous, active low): parse flags and valids cleared, separator 44, quote 34.
`default_nettype none

module csv_record_parser_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    csvp_in_if.sink                             i_in,
    csvp_out_if.source                          o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csvp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [csvp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [csvp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import csvp_pkg::*;

    t_cfg       w_cfg;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    t_state     r_state;
    t_state     n_state;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;

    logic       w_emit;
    t_kind      w_kind;
    logic [7:0] w_byte;
    logic       w_out_free;
    logic       w_fire;
    logic       w_in_take;

    csvp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    csvp_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_state (n_state),
        .o_emit  (w_emit),
        .o_kind  (w_kind),
        .o_byte  (w_byte)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && (!w_emit || w_out_free);
    assign i_in.ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
            if (w_fire && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_stream;
        end
        if (w_fire && w_emit) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_kind = 2'(r_out_kind);
    assign o_out.out_byte = r_out_byte;

    a_quote_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.in_quoted && r_state.after_closing_quote))
        else $error("in_quoted and after_closing_quote both set");

    a_cr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.after_record_cr |->
            (!r_state.in_quoted && !r_state.after_closing_quote && !r_state.field_has_data))
        else $error("record-ending CR flag set with stale record state");

    a_ctrl_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_DATA) |-> (r_out_byte == 8'd0))
        else $error("non-data result carries a byte");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_eos) |=> (r_state == '0))
        else $error("end of stream did not clear parse state");

endmodule

`default_nettype wire

FILE: tb/csv_record_parser_top_tb.sv
`timescale 1ns / 100ps

module csv_record_parser_top_tb;
    import csvp_pkg::*;

    localparam int LIMIT          = 1_000_000;
    localparam int PHASES         = 9;
    localparam int RAND_PER_PHASE = 205;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_csv_token;

    // Tracks the parse flags and the expected token stream of the parser.
    class csv_token_model;
        logic [7:0] sep   = SEP_RESET;
        logic [7:0] quote = QUOTE_RESET;
        bit in_quoted, after_close, has_data, after_cr;
        t_csv_token exp_q[$];
        int checked;
        int errors;

        function void clear_record();
            in_quoted   = 1'b0;
            after_close = 1'b0;
            has_data    = 1'b0;
            after_cr    = 1'b0;
        endfunction

        function void push_token(t_kind kind, logic [7:0] data);
            t_csv_token tok;
            tok.kind = kind;
            tok.data = data;
            exp_q.insert(exp_q.size(), tok);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            if (eos) begin
                push_token(has_data ? KIND_FIELD_RECORD : KIND_RECORD, 8'd0);
                clear_record();
                return;
            end
            if (after_cr) begin
                after_cr = 1'b0;
                if (b == CHAR_LF)
                    return;
            end
            // quote is tested ahead of the separator
            if (b == quote) begin
                if (in_quoted) begin
                    in_quoted   = 1'b0;
                    after_close = 1'b1;
                end else if (after_close) begin
                    after_close = 1'b0;
                    in_quoted   = 1'b1;
                    has_data    = 1'b1;
                    push_token(KIND_DATA, quote);
                end else begin
                    in_quoted = 1'b1;
                end
                return;
            end
            after_close = 1'b0;
            if (b == sep) begin
                if (in_quoted) begin
                    has_data = 1'b1;
                    push_token(KIND_DATA, b);
                end else begin
                    has_data = 1'b0;
                    push_token(KIND_FIELD, 8'd0);
                end
                return;
            end
            if (!in_quoted && (b == CHAR_CR || b == CHAR_LF)) begin
                clear_record();
                after_cr = (b == CHAR_CR);
                push_token(KIND_FIELD_RECORD, 8'd0);
                return;
            end
            has_data = 1'b1;
            push_token(KIND_DATA, b);
        endfunction

        function void check_token(logic [1:0] kind, logic [7:0] data);
            t_csv_token want;
            if (exp_q.size() == 0) begin
                note_error($sformatf("unexpected result: kind %0d byte 0x%02h", kind, data));
                return;
            end
            want = exp_q.pop_front();
            checked++;
            if (kind !== want.kind || data !== want.data)
                note_error($sformatf("result %0d: expected kind %0d byte 0x%02h, got kind %0d byte 0x%02h",
                                     checked, want.kind, want.data, kind, data));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    csvp_in_if  req_if ();
    csvp_out_if tok_if ();

    csv_record_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (tok_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csv_token_model tokens = new;

    int cycle_cnt;
    int reqs_sent;
    int eos_sent;
    int reg_writes;
    int rdy_hold;
    bit quiet;

    logic [7:0] sep_plan   [PHASES] = '{8'h2C, 8'h00, 8'hFF, 8'h3B, 8'h7C, 8'h0D, 8'h0A, 8'h00, 8'h2C};
    logic [7:0] quote_plan [PHASES] = '{8'h22, 8'hFF, 8'h00, 8'h27, 8'h7C, 8'h22, 8'h0D, 8'h00, 8'h22};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     tokens.exp_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(15, 40);
    endfunction

    // result side: check, then decide on back-pressure
    always @(posedge i_clk) begin
        if (tok_if.valid && tok_if.ready)
            tokens.check_token(tok_if.out_kind, tok_if.out_byte);
        if (!i_rst_n) begin
            tok_if.ready <= 1'b0;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (quiet) begin
            tok_if.ready <= 1'b1;
        end else if (tok_if.ready && $urandom_range(0, 99) < 30) begin
            tok_if.ready <= 1'b0;
            rdy_hold = idle_len() - 1;
        end else begin
            tok_if.ready <= 1'b1;
            rdy_hold = $urandom_range(0, 8);
        end
    end

    // Returns right after acceptance, or after the idle gap that follows it.
    // valid stays high when there is no gap.
    task automatic send_req(logic [7:0] b, logic eos);
        int gap;
        req_if.valid         <= 1'b1;
        req_if.in_byte       <= b;
        req_if.end_of_stream <= eos;
        do @(posedge i_clk); while (!req_if.ready);
        tokens.note_byte(b, eos);
        reqs_sent++;
        if (eos)
            eos_sent++;
        gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send_req(b, 1'b0);
    endtask

    task automatic send_eos();
        send_req(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 99) < 75)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_field();
        int n;
        int r;
        n = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 65) begin
            repeat (n) send_byte(text_byte());
            return;
        end
        send_byte(tokens.quote);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_byte(tokens.quote);
                send_byte(tokens.quote);
            end else if (r < 22) begin
                send_byte(tokens.sep);
            end else if (r < 28) begin
                send_byte(CHAR_CR);
            end else if (r < 34) begin
                send_byte(CHAR_LF);
            end else begin
                send_byte(text_byte());
            end
        end
        // occasionally leave the quoted section open, or run text on after it
        if ($urandom_range(0, 99) < 95)
            send_byte(tokens.quote);
        if ($urandom_range(0, 99) < 10)
            send_byte(text_byte());
    endtask

    task automatic send_record();
        int nf;
        int r;
        quiet = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 9) == 0)
                    send_eos();
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        nf = $urandom_range(0, 5);
        for (int i = 0; i < nf; i++) begin
            if (i > 0)
                send_byte(tokens.sep);
            send_field();
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end else if (r < 70) begin
            send_byte(CHAR_LF);
        end else if (r < 85) begin
            send_byte(CHAR_CR);
        end else if (r < 95) begin
            send_eos();
        end
    endtask

    // default separator and quote
    task automatic send_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h2C);
        send_byte(8'h22);       // open quote
        send_byte(8'h2C);       // separator as data
        send_byte(8'h0D);       // CR as data
        send_byte(8'h0A);
        send_byte(8'h22);
        send_byte(8'h22);       // doubled quote
        send_byte(8'h41);
        send_byte(8'h22);       // close
        send_byte(8'h0D);
        send_byte(8'h0A);       // swallowed
        send_byte(8'h61);
        send_byte(8'h22);       // quote mid-field
        send_byte(8'h2C);
        send_byte(8'h22);
        send_byte(8'h0A);
        send_eos();             // empty record
        send_eos();
        send_byte(8'h62);
        send_eos();             // field with data
        send_byte(8'h2C);
        send_byte(8'h0D);
        send_byte(8'h0D);       // CR right after CR
        send_byte(8'h0A);
        send_req(8'h00, 1'b1);
    endtask

    // wait until every expected result is back and the pipe has drained
    task automatic settle();
        req_if.valid <= 1'b0;
        while (tokens.exp_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_SEPARATOR)
            tokens.sep = val;
        else
            tokens.quote = val;
        reg_writes++;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== val)
            tokens.note_error($sformatf("register %s readback: expected 0x%02h, got 0x%02h",
                                        idx.name(), val, prdata[7:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int target;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.in_byte       <= 8'd0;
        req_if.end_of_stream <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        sep_plan[7]   = 8'($urandom_range(0, 255));
        quote_plan[7] = 8'($urandom_range(0, 255));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                write_reg(REG_SEPARATOR, sep_plan[ph]);
                write_reg(REG_QUOTE, quote_plan[ph]);
            end
            target = reqs_sent + RAND_PER_PHASE;
            while (reqs_sent < target)
                send_record();
        end
        quiet = 1'b0;
        settle();

        $display("summary: %0d requests (%0d end-of-stream), %0d results checked, %0d errors",
                 reqs_sent, eos_sent, tokens.checked, tokens.errors);
        $display("summary: %0d register writes, separator/quote incl. 0x00, 0xFF, equal, CR, LF",
                 reg_writes);
        if (tokens.errors == 0 && tokens.exp_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
